// ===== rtl/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared token codes and status codes for the postfix predicate evaluator.
// ----------------------------------------------------------------------------
package rpe_pkg;

    localparam int OP_WIDTH     = 4;
    localparam int STATUS_WIDTH = 2;
    localparam int PRED_WIDTH   = 32;
    localparam int OPND_WIDTH   = 32;

    // Token operation codes; codes nine to fifteen are no-ops
    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH = 4'd0,
        OP_GT   = 4'd1,
        OP_LT   = 4'd2,
        OP_GE   = 4'd3,
        OP_LE   = 4'd4,
        OP_EQ   = 4'd5,
        OP_NE   = 4'd6,
        OP_AND  = 4'd7,
        OP_OR   = 4'd8
    } op_t;

    // Row status codes; the first error of a row is kept
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

endpackage

// ===== rtl/rpe_alu.sv =====
// ----------------------------------------------------------------------------
// rpe_alu
// Binary operator unit: signed comparisons and logical AND/OR of the two
// topmost stack values, giving a 0/1 result and a flag for operator codes.
// ----------------------------------------------------------------------------
module rpe_alu
    import rpe_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  op_t                     op,
    input  logic signed [VALUE_WIDTH-1:0] a,    // lower entry
    input  logic signed [VALUE_WIDTH-1:0] b,    // top entry
    output logic                    is_binop,
    output logic                    result
);

    logic a_nz;
    logic b_nz;

    assign a_nz = (a != '0);
    assign b_nz = (b != '0);

    // Decode the operator and evaluate it
    always_comb begin
        is_binop = 1'b1;
        result   = 1'b0;
        unique case (op)
            OP_GT:   result = (a >  b);
            OP_LT:   result = (a <  b);
            OP_GE:   result = (a >= b);
            OP_LE:   result = (a <= b);
            OP_EQ:   result = (a == b);
            OP_NE:   result = (a != b);
            OP_AND:  result = a_nz && b_nz;
            OP_OR:   result = a_nz || b_nz;
            default: is_binop = 1'b0;
        endcase
    end

endmodule

// ===== rtl/rpn_predicate_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// rpn_predicate_evaluator_top
// Postfix WHERE-predicate evaluator: one token per transfer, one result per
// row on the token marked last.
// ----------------------------------------------------------------------------
// The block takes one token every clock cycle while s_ready is high; each
// token is fully evaluated in the cycle it is accepted. The two topmost stack
// entries live in registers, and deeper entries sit in a memory with one
// write and one registered read port that always prefetches the entry below
// the new top pair, so an operator never waits for the memory. The result of
// a row appears on the m_ side in the cycle after its last token is
// accepted when the output register is free. The output register is backed
// by a one-entry spare, so s_ready does not depend on m_ready and tokens keep
// flowing while one result waits to be taken; input stalls only once a second
// result is queued behind an untaken one, and resumes the cycle after the
// waiting result is taken. No clearing pass is needed after reset.
module rpn_predicate_evaluator_top
    import rpe_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [OP_WIDTH-1:0]          s_op,
    input  logic signed [OPND_WIDTH-1:0] s_operand,
    input  logic                         s_operand_present,
    input  logic                         s_last_token,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PRED_WIDTH-1:0] m_predicate_value,
    output logic [STATUS_WIDTH-1:0]      m_eval_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // Stack state
    logic [CW-1:0] cnt_reg, cnt_next;
    value_t        tos_reg, tos_next;
    value_t        nos_reg, nos_next;
    value_t        third_reg;
    status_t       err_reg, err_next;

    // Deeper stack entries
    value_t        mem [STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    value_t        mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Output register and its spare
    logic                         m_valid_reg;
    logic signed [PRED_WIDTH-1:0] pred_reg, pred_next;
    status_t                      status_reg;
    logic                         skid_valid_reg;
    logic signed [PRED_WIDTH-1:0] skid_pred_reg;
    status_t                      skid_status_reg;

    logic    accept;
    logic    row_done;
    op_t     op;
    value_t  push_val;
    logic    is_binop;
    logic    alu_res;
    logic    has_two;
    logic    is_full;
    status_t new_err;
    status_t row_err;
    logic [CW-1:0] cnt_eff;
    value_t        tos_eff;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign row_done = accept && s_last_token;
    assign op       = op_t'(s_op);

    // Zero for a missing column, then wrap to the stack value width
    assign push_val = s_operand_present ? VALUE_WIDTH'(s_operand) : '0;

    assign has_two = (cnt_reg >= CW'(2));
    assign is_full = (cnt_reg >= CW'(STACK_DEPTH));

    rpe_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .op      (op),
        .a       (nos_reg),
        .b       (tos_reg),
        .is_binop(is_binop),
        .result  (alu_res)
    );

    // Apply the token's effect to the stack
    always_comb begin
        cnt_eff   = cnt_reg;
        tos_eff   = tos_reg;
        nos_next  = nos_reg;
        new_err   = ST_OK;
        mem_we    = 1'b0;
        mem_waddr = AW'(cnt_reg);
        mem_wdata = push_val;
        if (op == OP_PUSH) begin
            if (is_full) begin
                new_err = ST_OVER;
            end else begin
                cnt_eff  = cnt_reg + CW'(1);
                tos_eff  = push_val;
                nos_next = tos_reg;
                mem_we   = 1'b1;
            end
        end else if (is_binop) begin
            if (!has_two) begin
                new_err = ST_UNDER;
            end else begin
                cnt_eff   = cnt_reg - CW'(1);
                tos_eff   = VALUE_WIDTH'(alu_res);
                nos_next  = third_reg;
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_reg - CW'(2));
                mem_wdata = VALUE_WIDTH'(alu_res);
            end
        end
        row_err = (err_reg == ST_OK) ? new_err : err_reg;
    end

    // Pick the next state; a last token clears the row
    always_comb begin
        cnt_next = cnt_reg;
        tos_next = tos_reg;
        err_next = err_reg;
        if (accept) begin
            tos_next = tos_eff;
            if (s_last_token) begin
                cnt_next = '0;
                err_next = ST_OK;
            end else begin
                cnt_next = cnt_eff;
                err_next = row_err;
            end
        end
        mem_raddr = AW'(cnt_next - CW'(3));
        pred_next = (cnt_eff != '0) ? PRED_WIDTH'(tos_eff) : PRED_WIDTH'(1);
    end

    // Stack control and cached top entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end else begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
        tos_reg <= tos_next;
        if (accept) begin
            nos_reg <= nos_next;
        end
    end

    // Write the stack memory and prefetch the entry below the top pair
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        third_reg <= mem[mem_raddr];
    end

    // Hold the row result until its transfer; park a second one in the spare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg || row_done;
            skid_valid_reg <= 1'b0;
        end else if (row_done) begin
            skid_valid_reg <= 1'b1;
        end
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                pred_reg   <= skid_pred_reg;
                status_reg <= skid_status_reg;
            end else if (row_done) begin
                pred_reg   <= pred_next;
                status_reg <= row_err;
            end
        end else if (row_done) begin
            skid_pred_reg   <= pred_next;
            skid_status_reg <= row_err;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicate_value = pred_reg;
    assign m_eval_status     = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_last_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_token |=> cnt_reg == '0 && err_reg == ST_OK)
        else $error("row state not cleared after last token");

    a_last_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_token |=> m_valid_reg)
        else $error("last token gave no result");

    a_status_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> status_reg == ST_OK || status_reg == ST_UNDER ||
                        status_reg == ST_OVER)
        else $error("bad status code on result");

    a_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_last_token |=> !m_valid_reg || $past(m_valid_reg))
        else $error("result raised without a last token");

endmodule
